// ===== rtl/gma_pkg.sv =====
// shared constants, types and command/status structs for the modularity accumulator
package gma_pkg;

   localparam int MAX_NODES = 1024;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int ACC_W     = 48;
   localparam int WEIGHT_W  = 24;
   localparam int RES_W     = 16;
   localparam int FRAC_BITS = 24;
   localparam int QUO_W     = FRAC_BITS + 1;
   localparam int SQ_W      = 2 * QUO_W;
   localparam int TERM_W    = SQ_W + RES_W - 36;
   localparam int SUM_W     = 40;
   localparam int OUT_W     = 32;
   localparam int STEP_W    = $clog2(FRAC_BITS + 1);

   localparam logic [RES_W-1:0] RES_RESET = RES_W'(4096);
   localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};

   localparam logic [1:0] OP_LABEL  = 2'd0;
   localparam logic [1:0] OP_EDGE   = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   typedef struct packed {
      logic lbl_wr;     // write node label from the request ports
      logic lbl_rd;     // read both end labels, latch the weight
      logic edge_rd;    // read accumulators at the source community
      logic edge_upd;   // read-modify-write of the edge update
      logic walk_rd;    // read entry at counter and zero it
      logic clr_wr;     // zero entry at counter
      logic cnt_clr;
      logic cnt_inc;
      logic div_start;
      logic mul_sq;
      logic mul_res;
      logic sum_add;
      logic sum_clr;
      logic emit;
   } gma_cmd_type;

   typedef struct packed {
      logic total_zero;
      logic deg_zero;
      logic div_done;
      logic cnt_last;
   } gma_status_type;

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                input logic [WEIGHT_W-1:0] w);
      logic [ACC_W:0] s;
      s = {1'b0, acc} + {{(ACC_W + 1 - WEIGHT_W){1'b0}}, w};
      return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
   endfunction

endpackage

// ===== rtl/gma_divider.sv =====
// restoring divider giving floor(num * 2^24 / den), capped at 1.0
module gma_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [gma_pkg::ACC_W-1:0]       num,
   input  logic [gma_pkg::ACC_W-1:0]       den,
   output logic                            done,
   output logic [gma_pkg::QUO_W-1:0]       quo
);

   logic [gma_pkg::ACC_W:0]         rem_ff, rem_in;
   logic [gma_pkg::FRAC_BITS-1:0]   quo_ff, quo_in;
   logic [gma_pkg::STEP_W-1:0]      step_ff, step_in;
   logic                            run_ff, run_in;
   logic                            cap_ff, cap_in;
   logic                            done_ff, done_in;
   logic [gma_pkg::ACC_W:0]         shifted;
   logic                            ge;

   assign shifted = {rem_ff[gma_pkg::ACC_W-1:0], 1'b0};
   assign ge      = shifted >= {1'b0, den};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      run_in  = run_ff;
      cap_in  = cap_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, num};
         quo_in  = '0;
         step_in = gma_pkg::STEP_W'(gma_pkg::FRAC_BITS);
         run_in  = 1'b1;
         cap_in  = num >= den;
      end else if (run_ff) begin
         rem_in  = ge ? shifted - {1'b0, den} : shifted;
         quo_in  = {quo_ff[gma_pkg::FRAC_BITS-2:0], ge};
         step_in = step_ff - 1'b1;
         if (step_ff == gma_pkg::STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cap_ff <= cap_in;
   end

   assign done = done_ff;
   assign quo  = cap_ff ? {1'b1, {gma_pkg::FRAC_BITS{1'b0}}} : {1'b0, quo_ff};

endmodule

// ===== rtl/gma_ctrl.sv =====
// sequencer for label writes, edge updates, clearing pass and the finish walk
module gma_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              req_opcode,
   input  gma_pkg::gma_status_type status,
   output gma_pkg::gma_cmd_type    cmd,
   output logic                    busy
);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_EDGE_RD  = 4'd2;
   localparam logic [3:0] S_EDGE_WR  = 4'd3;
   localparam logic [3:0] S_WALK_RD  = 4'd4;
   localparam logic [3:0] S_WALK_CHK = 4'd5;
   localparam logic [3:0] S_DIV      = 4'd6;
   localparam logic [3:0] S_MUL_SQ   = 4'd7;
   localparam logic [3:0] S_MUL_RES  = 4'd8;
   localparam logic [3:0] S_SUM      = 4'd9;
   localparam logic [3:0] S_FIN      = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       accept;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = state_ff != S_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr  = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (status.cnt_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  gma_pkg::OP_LABEL: cmd.lbl_wr = 1'b1;
                  gma_pkg::OP_EDGE: begin
                     cmd.lbl_rd = 1'b1;
                     state_in   = S_EDGE_RD;
                  end
                  gma_pkg::OP_FINISH: begin
                     if (status.total_zero) begin
                        cmd.emit = 1'b1;
                     end else begin
                        cmd.sum_clr = 1'b1;
                        cmd.cnt_clr = 1'b1;
                        state_in    = S_WALK_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_EDGE_RD: begin
            cmd.edge_rd = 1'b1;
            state_in    = S_EDGE_WR;
         end
         S_EDGE_WR: begin
            cmd.edge_upd = 1'b1;
            state_in     = S_IDLE;
         end
         S_WALK_RD: begin
            cmd.walk_rd = 1'b1;
            state_in    = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            if (status.deg_zero) begin
               if (status.cnt_last) begin
                  state_in = S_FIN;
               end else begin
                  cmd.cnt_inc = 1'b1;
                  state_in    = S_WALK_RD;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (status.div_done) state_in = S_MUL_SQ;
         end
         S_MUL_SQ: begin
            cmd.mul_sq = 1'b1;
            state_in   = S_MUL_RES;
         end
         S_MUL_RES: begin
            cmd.mul_res = 1'b1;
            state_in    = S_SUM;
         end
         S_SUM: begin
            cmd.sum_add = 1'b1;
            if (status.cnt_last) begin
               state_in = S_FIN;
            end else begin
               cmd.cnt_inc = 1'b1;
               state_in    = S_WALK_RD;
            end
         end
         S_FIN: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/gma_datapath.sv =====
// label and accumulator memories, dividers, multipliers and the modularity sum
module gma_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  gma_pkg::gma_cmd_type               cmd,
   output gma_pkg::gma_status_type            status,
   input  logic [gma_pkg::NODE_W-1:0]         req_node_index,
   input  logic [gma_pkg::NODE_W-1:0]         req_neighbor_index,
   input  logic [gma_pkg::NODE_W-1:0]         req_community,
   input  logic [gma_pkg::WEIGHT_W-1:0]       req_weight,
   input  logic                               csr_write_enable,
   input  logic [gma_pkg::RES_W-1:0]          csr_write_data,
   output logic                               rsp_strobe,
   output logic signed [gma_pkg::OUT_W-1:0]   rsp_modularity,
   output logic                               rsp_empty_graph
);

   logic [gma_pkg::NODE_W-1:0]   label_mem [gma_pkg::MAX_NODES];
   logic [gma_pkg::ACC_W-1:0]    deg_mem   [gma_pkg::MAX_NODES];
   logic [gma_pkg::ACC_W-1:0]    int_mem   [gma_pkg::MAX_NODES];

   logic [gma_pkg::NODE_W-1:0]   src_comm_ff, dst_comm_ff;
   logic [gma_pkg::WEIGHT_W-1:0] weight_ff;
   logic [gma_pkg::ACC_W-1:0]    deg_rd_ff, int_rd_ff;
   logic [gma_pkg::ACC_W-1:0]    total_ff;
   logic [gma_pkg::RES_W-1:0]    resolution_ff;
   logic [gma_pkg::NODE_W-1:0]   cnt_ff;
   logic [gma_pkg::SQ_W-1:0]     sq_ff;
   logic [gma_pkg::TERM_W-1:0]   term_ff;
   logic signed [gma_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic                         strobe_ff;
   logic signed [gma_pkg::OUT_W-1:0] mod_ff;
   logic                         empty_ff;

   logic                         acc_rd, acc_we, int_we;
   logic [gma_pkg::NODE_W-1:0]   acc_addr;
   logic [gma_pkg::ACC_W-1:0]    deg_wdata, int_wdata;
   logic [gma_pkg::QUO_W-1:0]    quo_int, quo_deg;
   logic                         done_int, done_deg;
   logic [gma_pkg::SQ_W+gma_pkg::RES_W-1:0] res_prod;
   logic signed [gma_pkg::OUT_W-1:0] sum_sat;

   // label store: written from the ports, two read ports for edge ends
   always_ff @(posedge clock) begin
      if (cmd.lbl_wr) label_mem[req_node_index] <= req_community;
      if (cmd.lbl_rd) begin
         src_comm_ff <= label_mem[req_node_index];
         dst_comm_ff <= label_mem[req_neighbor_index];
         weight_ff   <= req_weight;
      end
   end

   assign acc_rd   = cmd.edge_rd || cmd.walk_rd;
   assign acc_addr = (cmd.edge_rd || cmd.edge_upd) ? src_comm_ff : cnt_ff;
   assign acc_we   = cmd.edge_upd || cmd.walk_rd || cmd.clr_wr;
   assign int_we   = cmd.walk_rd || cmd.clr_wr || (cmd.edge_upd && src_comm_ff == dst_comm_ff);
   assign deg_wdata = cmd.edge_upd ? gma_pkg::sat_add(deg_rd_ff, weight_ff) : '0;
   assign int_wdata = cmd.edge_upd ? gma_pkg::sat_add(int_rd_ff, weight_ff) : '0;

   always_ff @(posedge clock) begin
      if (acc_we) deg_mem[acc_addr] <= deg_wdata;
      if (int_we) int_mem[acc_addr] <= int_wdata;
      if (acc_rd) begin
         deg_rd_ff <= deg_mem[acc_addr];
         int_rd_ff <= int_mem[acc_addr];
      end
   end

   gma_divider u_div_int (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (int_rd_ff),
      .den   (total_ff),
      .done  (done_int),
      .quo   (quo_int)
   );

   gma_divider u_div_deg (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (deg_rd_ff),
      .den   (total_ff),
      .done  (done_deg),
      .quo   (quo_deg)
   );

   assign res_prod = resolution_ff * sq_ff;

   always_comb begin
      sum_in = sum_ff
             + $signed({{(gma_pkg::SUM_W - gma_pkg::QUO_W){1'b0}}, quo_int})
             - $signed({{(gma_pkg::SUM_W - gma_pkg::TERM_W){1'b0}}, term_ff});
   end

   always_comb begin
      if (sum_ff > gma_pkg::SUM_W'(32'sh7FFF_FFFF)) begin
         sum_sat = {1'b0, {(gma_pkg::OUT_W-1){1'b1}}};
      end else if (sum_ff < -$signed(gma_pkg::SUM_W'(33'sh0_8000_0000))) begin
         sum_sat = {1'b1, {(gma_pkg::OUT_W-1){1'b0}}};
      end else begin
         sum_sat = sum_ff[gma_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_sq)  sq_ff   <= quo_deg * quo_deg;
      if (cmd.mul_res) term_ff <= res_prod[gma_pkg::SQ_W+gma_pkg::RES_W-1:36];
      if (cmd.sum_clr) begin
         sum_ff <= '0;
      end else if (cmd.sum_add) begin
         sum_ff <= sum_in;
      end
      if (cmd.emit) begin
         mod_ff   <= status.total_zero ? '0 : sum_sat;
         empty_ff <= status.total_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= '0;
         resolution_ff <= gma_pkg::RES_RESET;
         cnt_ff        <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         if (cmd.edge_upd) begin
            total_ff <= gma_pkg::sat_add(total_ff, weight_ff);
         end else if (cmd.emit) begin
            total_ff <= '0;
         end
         if (csr_write_enable) resolution_ff <= csr_write_data;
         if (cmd.cnt_clr) begin
            cnt_ff <= '0;
         end else if (cmd.cnt_inc) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         strobe_ff <= cmd.emit;
      end
   end

   assign status.total_zero = total_ff == '0;
   assign status.deg_zero   = deg_rd_ff == '0;
   assign status.div_done   = done_int && done_deg;
   assign status.cnt_last   = cnt_ff == gma_pkg::NODE_W'(gma_pkg::MAX_NODES - 1);

   assign rsp_strobe      = strobe_ff;
   assign rsp_modularity  = mod_ff;
   assign rsp_empty_graph = empty_ff;

endmodule

// ===== rtl/graph_modularity_accumulator.sv =====
// top level of the weighted-graph modularity accumulator
// usage
//  - items enter on req_* and are taken at a clock edge with start high and busy low
//  - opcode label: stores req_community for req_node_index, busy stays low
//  - opcode edge: adds req_weight to the total, to the source community's degree,
//    and to its internal weight when both ends share a label, by a label read,
//    accumulator read and write through one memory port; busy until the write
//  - opcode finish: walks all 1024 communities and emits one result item;
//    an empty community is only read and checked, a used one also passes
//    through two 24-step restoring dividers, square, resolution multiply, sum
//  - finish with zero total weight emits modularity 0 and empty_graph the next cycle
//  - the walk zeroes the accumulators behind it; node labels are kept
//  - the result item sits on rsp_* for one cycle with rsp_strobe high;
//    the receiver cannot hold it off
//  - csr_write_enable sets resolution (Q4.12) unchecked; user sets it only when idle
// reset
//  - synchronous, active high; resolution returns to 1.0
//  - a clearing pass then zeroes all 1024 entries of the accumulator memories,
//    busy is high throughout and no item is taken
//  - labels are undefined until written
module graph_modularity_accumulator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_opcode,
   input  logic [gma_pkg::NODE_W-1:0]         req_node_index,
   input  logic [gma_pkg::NODE_W-1:0]         req_neighbor_index,
   input  logic [gma_pkg::NODE_W-1:0]         req_community,
   input  logic [gma_pkg::WEIGHT_W-1:0]       req_weight,
   output logic                               rsp_strobe,
   output logic signed [gma_pkg::OUT_W-1:0]   rsp_modularity,
   output logic                               rsp_empty_graph,
   input  logic                               csr_write_enable,
   input  logic [gma_pkg::RES_W-1:0]          csr_write_data
);

   // command and status between sequencer and datapath
   gma_pkg::gma_cmd_type    cmd;
   gma_pkg::gma_status_type status;

   // sequencer: clearing pass, label writes, edge read-modify-write, finish walk
   gma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   // memories, arithmetic and the result register
   gma_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_node_index     (req_node_index),
      .req_neighbor_index (req_neighbor_index),
      .req_community      (req_community),
      .req_weight         (req_weight),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_modularity     (rsp_modularity),
      .rsp_empty_graph    (rsp_empty_graph)
   );

   // an empty graph always reports zero modularity
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_empty_graph |-> rsp_modularity == '0)
      else $error("empty graph result with nonzero modularity");

   // an accepted edge item keeps the block busy for its update
   a_edge_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode == gma_pkg::OP_EDGE |=> busy)
      else $error("edge item did not occupy the block");

   // the clearing pass follows reset
   a_clear_busy: assert property (@(posedge clock)
      reset |=> busy)
      else $error("block idle right after reset");

   // a label item never produces a result
   a_label_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode == gma_pkg::OP_LABEL |=> !rsp_strobe)
      else $error("label item produced a result");

endmodule

// ===== tb/graph_modularity_accumulator_test.sv =====
// testbench for the weighted-graph modularity accumulator
`timescale 1ns / 100ps

module graph_modularity_accumulator_test;

   // wait allowed after the last result before the csr is touched
   localparam int SETTLE_CYCLES = 8;
   // cycles with no item taken and no result seen before giving up
   localparam int STALL_LIMIT   = 200000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [gma_pkg::OUT_W-1:0] modularity;
      logic                             empty_graph;
   } score_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic [1:0]                       req_opcode = gma_pkg::OP_LABEL;
   logic [gma_pkg::NODE_W-1:0]       req_node_index = '0;
   logic [gma_pkg::NODE_W-1:0]       req_neighbor_index = '0;
   logic [gma_pkg::NODE_W-1:0]       req_community = '0;
   logic [gma_pkg::WEIGHT_W-1:0]     req_weight = '0;
   logic                             rsp_strobe;
   logic signed [gma_pkg::OUT_W-1:0] rsp_modularity;
   logic                             rsp_empty_graph;
   logic                             csr_write_enable = 1'b0;
   logic [gma_pkg::RES_W-1:0]        csr_write_data = '0;

   // predictor state
   logic [gma_pkg::NODE_W-1:0] node_label [gma_pkg::MAX_NODES];
   bit                         node_labeled [gma_pkg::MAX_NODES];
   int                         labeled_nodes [$];
   logic [gma_pkg::ACC_W-1:0]  comm_internal [gma_pkg::MAX_NODES];
   logic [gma_pkg::ACC_W-1:0]  comm_degree [gma_pkg::MAX_NODES];
   logic [gma_pkg::ACC_W-1:0]  graph_weight;
   logic [gma_pkg::RES_W-1:0]  resolution_q12;

   score_type pending_scores [$];
   int     error_count = 0;
   int     items_sent = 0;
   int     scores_seen = 0;
   int     empty_seen = 0;
   int     stall_count = 0;
   bit     gaps_enabled = 1'b1;

   graph_modularity_accumulator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_node_index(req_node_index),
      .req_neighbor_index(req_neighbor_index), .req_community(req_community),
      .req_weight(req_weight), .rsp_strobe(rsp_strobe),
      .rsp_modularity(rsp_modularity), .rsp_empty_graph(rsp_empty_graph),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #4 clock = ~clock;

   // one line per mismatch, counted
   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // saturating 48-bit add
   function automatic logic [gma_pkg::ACC_W-1:0] add_capped(
         input logic [gma_pkg::ACC_W-1:0] acc,
         input logic [gma_pkg::WEIGHT_W-1:0] w);
      logic [gma_pkg::ACC_W:0] s;
      s = {1'b0, acc} + (gma_pkg::ACC_W + 1)'(w);
      if (s[gma_pkg::ACC_W]) return {gma_pkg::ACC_W{1'b1}};
      return s[gma_pkg::ACC_W-1:0];
   endfunction

   // x / total as a Q1.24 share, capped at one
   function automatic logic [24:0] share_q24(input logic [gma_pkg::ACC_W-1:0] x,
                                             input logic [gma_pkg::ACC_W-1:0] total);
      logic [79:0] num;
      if (x >= total) return 25'(1 << 24);
      num = {8'd0, x, 24'd0};
      return 25'(num / {32'd0, total});
   endfunction

   // modularity of the accumulated graph, then the accumulators clear
   function automatic score_type finish_graph();
      score_type r;
      longint q;
      logic [24:0] a, f;
      logic [79:0] term;
      q = 0;
      r.empty_graph = (graph_weight == '0);
      if (!r.empty_graph) begin
         for (int c = 0; c < gma_pkg::MAX_NODES; c++) begin
            a = share_q24(comm_internal[c], graph_weight);
            f = share_q24(comm_degree[c], graph_weight);
            term = 80'(resolution_q12) * 80'(f) * 80'(f);
            q += longint'(a) - longint'(term >> 36);
         end
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
      end
      r.modularity = q[gma_pkg::OUT_W-1:0];
      for (int c = 0; c < gma_pkg::MAX_NODES; c++) begin
         comm_internal[c] = '0;
         comm_degree[c] = '0;
      end
      graph_weight = '0;
      return r;
   endfunction

   // advance the predictor by one taken item
   task automatic predict_item(input logic [1:0] op,
                               input logic [gma_pkg::NODE_W-1:0] node,
                               input logic [gma_pkg::NODE_W-1:0] nb,
                               input logic [gma_pkg::NODE_W-1:0] comm,
                               input logic [gma_pkg::WEIGHT_W-1:0] w);
      logic [gma_pkg::NODE_W-1:0] cs;
      case (op)
         gma_pkg::OP_LABEL: begin
            node_label[node] = comm;
            if (!node_labeled[node]) begin
               node_labeled[node] = 1'b1;
               labeled_nodes.push_back(int'(node));
            end
         end
         gma_pkg::OP_EDGE: begin
            cs = node_label[node];
            graph_weight = add_capped(graph_weight, w);
            comm_degree[cs] = add_capped(comm_degree[cs], w);
            if (cs == node_label[nb]) comm_internal[cs] = add_capped(comm_internal[cs], w);
         end
         gma_pkg::OP_FINISH: pending_scores.push_back(finish_graph());
         default: ;
      endcase
   endtask

   // present one item and hold it until taken; start stays high afterward unless a gap follows
   task automatic send_item(input logic [1:0] op,
                            input logic [gma_pkg::NODE_W-1:0] node,
                            input logic [gma_pkg::NODE_W-1:0] nb,
                            input logic [gma_pkg::NODE_W-1:0] comm,
                            input logic [gma_pkg::WEIGHT_W-1:0] w);
      req_opcode <= op;
      req_node_index <= node;
      req_neighbor_index <= nb;
      req_community <= comm;
      req_weight <= w;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predict_item(op, node, nb, comm, w);
      items_sent++;
      // random gap after the item, unless in the no-gap stretch
      if (gaps_enabled && $urandom_range(99) < 34) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic label_node(input int node, input int comm);
      send_item(gma_pkg::OP_LABEL, gma_pkg::NODE_W'(node), gma_pkg::NODE_W'($urandom),
                gma_pkg::NODE_W'(comm), gma_pkg::WEIGHT_W'($urandom));
   endtask

   task automatic add_edge(input int src, input int dst,
                           input logic [gma_pkg::WEIGHT_W-1:0] w);
      send_item(gma_pkg::OP_EDGE, gma_pkg::NODE_W'(src), gma_pkg::NODE_W'(dst),
                gma_pkg::NODE_W'($urandom), w);
   endtask

   task automatic finish_item();
      send_item(gma_pkg::OP_FINISH, gma_pkg::NODE_W'($urandom), gma_pkg::NODE_W'($urandom),
                gma_pkg::NODE_W'($urandom), gma_pkg::WEIGHT_W'($urandom));
   endtask

   task automatic unused_item();
      send_item(OP_UNUSED, gma_pkg::NODE_W'($urandom), gma_pkg::NODE_W'($urandom),
                gma_pkg::NODE_W'($urandom), gma_pkg::WEIGHT_W'($urandom));
   endtask

   // sender holds off until every score is back and the block is quiet
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic set_resolution(input logic [gma_pkg::RES_W-1:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      resolution_q12 = value;
   endtask

   // empty graph, field extremes, internal vs cross edges, unused opcode
   task automatic test_directed();
      finish_item();
      label_node(0, 0);
      label_node(gma_pkg::MAX_NODES - 1, gma_pkg::MAX_NODES - 1);
      label_node(5, gma_pkg::MAX_NODES - 1);
      label_node(6, 0);
      add_edge(0, 6, {gma_pkg::WEIGHT_W{1'b1}});
      add_edge(6, 0, {gma_pkg::WEIGHT_W{1'b1}});
      add_edge(gma_pkg::MAX_NODES - 1, 5, 24'h010000);
      add_edge(5, 0, 24'h000001);
      add_edge(0, gma_pkg::MAX_NODES - 1, '0);
      send_item(OP_UNUSED, {gma_pkg::NODE_W{1'b1}}, {gma_pkg::NODE_W{1'b1}},
                {gma_pkg::NODE_W{1'b1}}, {gma_pkg::WEIGHT_W{1'b1}});
      finish_item();
      // finish right after finish sees the cleared accumulators
      finish_item();
      // zero-weight edges alone still leave the graph empty
      add_edge(0, 6, '0);
      finish_item();
   endtask

   // one community holds everything: both shares cap at one
   task automatic test_single_community();
      label_node(6, 0);
      label_node(5, 0);
      add_edge(6, 5, 24'h123456);
      add_edge(5, 6, 24'h123456);
      finish_item();
      label_node(5, gma_pkg::MAX_NODES - 1);
   endtask

   // mostly edge runs among labeled nodes, some relabels, finishes, unused ops
   task automatic test_random_graph(input int count);
      int pick, src, dst;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 14 || labeled_nodes.size() < 2) begin
            if ($urandom_range(3) == 0) label_node($urandom_range(gma_pkg::MAX_NODES - 1),
                                                   $urandom_range(gma_pkg::MAX_NODES - 1));
            else label_node($urandom_range(31), $urandom_range(7));
         end else if (pick < 90) begin
            src = labeled_nodes[$urandom_range(labeled_nodes.size() - 1)];
            dst = labeled_nodes[$urandom_range(labeled_nodes.size() - 1)];
            add_edge(src, dst, ($urandom_range(3) == 0) ? 24'($urandom) :
                               24'($urandom_range(24'h03FFFF)));
         end else if (pick < 96) begin
            finish_item();
         end else begin
            unused_item();
         end
      end
      finish_item();
   endtask

   // result check and watchdog
   always @(posedge clock) begin
      score_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) stall_count <= 0;
         else stall_count <= stall_count + 1;
         if (rsp_strobe) begin
            scores_seen++;
            if (rsp_empty_graph) empty_seen++;
            if (pending_scores.size() == 0) begin
               report_mismatch("result with no finish item waiting");
            end else begin
               want = pending_scores.pop_front();
               if (rsp_modularity !== want.modularity)
                  report_mismatch($sformatf("modularity %0d, expected %0d",
                                            rsp_modularity, want.modularity));
               if (rsp_empty_graph !== want.empty_graph)
                  report_mismatch($sformatf("empty_graph %0b, expected %0b",
                                            rsp_empty_graph, want.empty_graph));
            end
         end
         if (stall_count >= STALL_LIMIT) begin
            $display("graph_modularity_accumulator_test: done, errors");
            $finish;
         end
      end
   end

   initial begin
      for (int c = 0; c < gma_pkg::MAX_NODES; c++) begin
         node_label[c] = '0;
         node_labeled[c] = 1'b0;
         comm_internal[c] = '0;
         comm_degree[c] = '0;
      end
      graph_weight = '0;
      resolution_q12 = gma_pkg::RES_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_single_community();
      test_random_graph(220);
      set_resolution('0);
      test_random_graph(200);
      set_resolution({gma_pkg::RES_W{1'b1}});
      test_directed();
      test_random_graph(200);
      set_resolution(gma_pkg::RES_W'($urandom));
      // long stretch with the sender never pausing
      gaps_enabled = 1'b0;
      test_random_graph(150);
      gaps_enabled = 1'b1;
      set_resolution(gma_pkg::RES_RESET);
      test_random_graph(150);

      drain();
      if (pending_scores.size() != 0) report_mismatch("finish items left without a result");
      $display("covered %0d items and %0d results (%0d on an empty graph)",
               items_sent, scores_seen, empty_seen);
      $display("resolutions swept: reset value, zero, maximum, random, back to reset");
      if (error_count == 0) begin
         $display("graph_modularity_accumulator_test: done, clean");
      end else begin
         $display("graph_modularity_accumulator_test: done, errors");
      end
      $finish;
   end

endmodule
